/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Clock and reset are taken from the
// enclosing module's clk_i and rst_ni ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define IRMC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("irmc assertion failed");

// Condition must never be true outside reset.
`define IRMC_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("irmc forbidden condition seen");

`endif

/* rtl/irmc_pkg.sv */
package irmc_pkg;

  localparam int MACRO_SLOTS       = 20;
  localparam int SIGNALS_PER_MACRO = 4;
  localparam int FRAME_LIMIT       = 20;

  // Leading frame bytes that carry meaning: command plus five arguments.
  localparam int FRAME_KEEP = 6;

  localparam int SLOT_IDX_W = $clog2(MACRO_SLOTS);
  localparam int CNT_W      = $clog2(SIGNALS_PER_MACRO + 1);
  localparam int SIG_W      = (SIGNALS_PER_MACRO > 1) ? $clog2(SIGNALS_PER_MACRO) : 1;
  localparam int TBL_DEPTH  = MACRO_SLOTS * SIGNALS_PER_MACRO;
  localparam int ADDR_W     = $clog2(TBL_DEPTH);
  localparam int POS_W      = $clog2(FRAME_LIMIT);
  localparam int SIGNAL_W   = 40;

  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] CMD_SEND  = 8'h53;
  localparam logic [7:0] CMD_STAGE = 8'h55;
  localparam logic [7:0] CMD_ITEM  = 8'h49;
  localparam logic [7:0] CMD_WRITE = 8'h57;

  // A completed frame as seen on the cycle its carriage return arrives.
  typedef struct packed {
    logic                            done;
    logic [FRAME_KEEP-1:0][7:0]      bytes;
  } frame_t;

endpackage

/* rtl/irmc_ram.sv */
module irmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/irmc_framer.sv */
module irmc_framer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_en_i,
  input  logic [7:0]      rx_byte_i,
  output irmc_pkg::frame_t frame_o
);
  import irmc_pkg::*;

  logic [POS_W-1:0]           pos_q, pos_d;
  logic [FRAME_KEEP-1:0][7:0] bytes_q, bytes_d;
  logic [FRAME_KEEP-1:0][7:0] merged;
  logic [POS_W:0]             pos_inc;
  logic                       overflow;
  logic                       is_cr;

  always_comb begin
    for (int k = 0; k < FRAME_KEEP; k++) begin
      merged[k] = (pos_q == POS_W'(k)) ? rx_byte_i : bytes_q[k];
    end
  end

  assign pos_inc  = {1'b0, pos_q} + (POS_W+1)'(1);
  assign overflow = (pos_inc >= (POS_W+1)'(FRAME_LIMIT));
  assign is_cr    = (rx_byte_i == BYTE_CR);

  always_comb begin
    pos_d   = pos_q;
    bytes_d = bytes_q;
    if (byte_en_i) begin
      // Drop the frame on overflow or close it on carriage return.
      if (overflow || is_cr) begin
        pos_d   = '0;
        bytes_d = '0;
      end else begin
        pos_d   = pos_inc[POS_W-1:0];
        bytes_d = merged;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bytes_q <= '0;
    end else begin
      pos_q   <= pos_d;
      bytes_q <= bytes_d;
    end
  end

  assign frame_o.done  = byte_en_i && is_cr && !overflow;
  assign frame_o.bytes = merged;

endmodule

/* rtl/ir_macro_command_store.sv */
// IR macro command store. Serial words from a UART are framed up to a carriage
// return and decoded by their first byte: U stages a macro (slot, count), I
// appends one signal (protocol, big-endian address, big-endian command), W
// commits the staged macro to the table and S plays a stored slot; a button
// press plays slot 0 to 7. Each played signal leaves as one output word, the
// final one with last_o set. A serial word or a button press that plays
// nothing leaves the input unstalled. W holds the input stalled while the
// staged signals are copied into the table memory, one entry per cycle
// through its single write port. A play holds the input stalled and, for
// each signal, reads the table memory and then loads the output register;
// an output stall holds the play before the load. Signal counts live in
// flip-flops cleared by reset; a table entry is only read once its slot has
// been written, so the table memory needs no clearing pass.
module ir_macro_command_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [2:0]  button_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  slot_o,
  output logic [7:0]  protocol_o,
  output logic [15:0] address_o,
  output logic [15:0] command_o,
  output logic        last_o
);
  `include "assert_macros.svh"
  import irmc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_e;

  state_e st_q, st_d;

  // Handshake and framing.
  logic   in_acc;
  frame_t frm;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  irmc_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_en_i(in_acc && !action_i),
    .rx_byte_i(rx_byte_i),
    .frame_o  (frm)
  );

  logic is_send, is_stage, is_item, is_write;
  assign is_send  = frm.done && (frm.bytes[0] == CMD_SEND);
  assign is_stage = frm.done && (frm.bytes[0] == CMD_STAGE);
  assign is_item  = frm.done && (frm.bytes[0] == CMD_ITEM);
  assign is_write = frm.done && (frm.bytes[0] == CMD_WRITE);

  // Staging registers.
  logic [7:0]          stg_slot_q;
  logic [CNT_W-1:0]    stg_cnt_q;
  logic [CNT_W-1:0]    stg_fill_q;
  logic [SIGNAL_W-1:0] stg_sig_q [SIGNALS_PER_MACRO];

  // Per-slot signal counts.
  logic [CNT_W-1:0] cnt_q [MACRO_SLOTS];

  // Sequencer registers: base and index shared by commit and play, count and slot for play.
  logic [ADDR_W-1:0] base_q, base_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  num_q, num_d;
  logic [7:0]        pslot_q, pslot_d;

  // Play and write request decode.
  logic [7:0]          play_slot;
  logic                play_req, play_ok, go_play;
  logic [SLOT_IDX_W-1:0] play_idx;
  logic [CNT_W-1:0]    play_num;
  logic                wr_ok, go_write;
  logic [SLOT_IDX_W-1:0] wr_idx;

  assign play_slot = action_i ? {5'b0, button_i} : frm.bytes[1];
  assign play_req  = (in_acc && action_i) || is_send;
  assign play_ok   = ({1'b0, play_slot} < 9'(MACRO_SLOTS));
  assign play_idx  = play_ok ? play_slot[SLOT_IDX_W-1:0] : '0;
  assign play_num  = cnt_q[play_idx];
  assign go_play   = play_req && play_ok && (play_num != '0);

  assign wr_ok    = ({1'b0, stg_slot_q} < 9'(MACRO_SLOTS));
  assign wr_idx   = wr_ok ? stg_slot_q[SLOT_IDX_W-1:0] : '0;
  assign go_write = is_write && wr_ok;

  // Output register.
  logic        out_valid_q;
  logic [4:0]  slot_q;
  logic [7:0]  prot_q;
  logic [15:0] addr_q;
  logic [15:0] cmd_q;
  logic        last_q;
  logic        out_free, out_load, load_last;

  // Table memory ports.
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SIGNAL_W-1:0] ram_rdata;

  assign ram_addr  = base_q + ADDR_W'(idx_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_last = ((idx_q + CNT_W'(1)) == num_q);

  always_comb begin
    st_d     = st_q;
    base_d   = base_q;
    idx_d    = idx_q;
    num_d    = num_q;
    pslot_d  = pslot_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (go_write) begin
          base_d = ADDR_W'(wr_idx) * ADDR_W'(SIGNALS_PER_MACRO);
          idx_d  = '0;
          st_d   = ST_WRITE;
        end else if (go_play) begin
          base_d  = ADDR_W'(play_idx) * ADDR_W'(SIGNALS_PER_MACRO);
          idx_d   = '0;
          num_d   = play_num;
          pslot_d = play_slot;
          st_d    = ST_READ;
        end
      end
      ST_WRITE: begin
        // Copy one staged signal per cycle.
        ram_we = 1'b1;
        if (idx_q == CNT_W'(SIGNALS_PER_MACRO - 1)) begin
          st_d = ST_IDLE;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
        st_d   = ST_LOAD;
      end
      ST_LOAD: begin
        // Hold the read data until the output register frees up.
        if (out_free) begin
          out_load = 1'b1;
          if (load_last) begin
            st_d = ST_IDLE;
          end else begin
            idx_d = idx_q + CNT_W'(1);
            st_d  = ST_READ;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  irmc_ram #(
    .WIDTH(SIGNAL_W),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(stg_sig_q[idx_q[SIG_W-1:0]]),
    .re_i   (ram_re),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      base_q  <= '0;
      idx_q   <= '0;
      num_q   <= '0;
      pslot_q <= '0;
    end else begin
      st_q    <= st_d;
      base_q  <= base_d;
      idx_q   <= idx_d;
      num_q   <= num_d;
      pslot_q <= pslot_d;
    end
  end

  // Staging and counts: U clears and arms, I appends, W commits the count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_slot_q <= '0;
      stg_cnt_q  <= '0;
      stg_fill_q <= '0;
      for (int k = 0; k < SIGNALS_PER_MACRO; k++) begin
        stg_sig_q[k] <= '0;
      end
      for (int k = 0; k < MACRO_SLOTS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (is_stage) begin
        for (int k = 0; k < SIGNALS_PER_MACRO; k++) begin
          stg_sig_q[k] <= '0;
        end
        stg_fill_q <= '0;
        stg_slot_q <= frm.bytes[1];
        if (frm.bytes[2] > 8'(SIGNALS_PER_MACRO)) begin
          stg_cnt_q <= CNT_W'(SIGNALS_PER_MACRO);
        end else begin
          stg_cnt_q <= frm.bytes[2][CNT_W-1:0];
        end
      end
      if (is_item && (stg_fill_q < CNT_W'(SIGNALS_PER_MACRO))) begin
        stg_sig_q[stg_fill_q[SIG_W-1:0]] <= {frm.bytes[1], frm.bytes[2], frm.bytes[3],
                                             frm.bytes[4], frm.bytes[5]};
        stg_fill_q <= stg_fill_q + CNT_W'(1);
      end
      if (go_write && (st_q == ST_IDLE)) begin
        cnt_q[wr_idx] <= stg_cnt_q;
      end
    end
  end

  // Output word register; advance when taken, load when free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      slot_q <= pslot_q[4:0];
      prot_q <= ram_rdata[39:32];
      addr_q <= ram_rdata[31:16];
      cmd_q  <= ram_rdata[15:0];
      last_q <= load_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign protocol_o  = prot_q;
  assign address_o   = addr_q;
  assign command_o   = cmd_q;
  assign last_o      = last_q;

  `IRMC_ASSERT(a_last_ends_play, (st_q == ST_LOAD && out_load && load_last) |=> (st_q == ST_IDLE))
  `IRMC_ASSERT(a_play_in_range, (st_q == ST_READ || st_q == ST_LOAD) |-> (num_q != '0 && idx_q < num_q))
  `IRMC_ASSERT(a_write_in_range, (st_q == ST_WRITE) |-> (idx_q < CNT_W'(SIGNALS_PER_MACRO)))
  `IRMC_ASSERT_NEVER(a_fill_bound, stg_fill_q > CNT_W'(SIGNALS_PER_MACRO))
  `IRMC_ASSERT_NEVER(a_load_overwrite, out_load && out_valid_q && out_stall_i)

endmodule
